// ===== rtl/stts_pkg.sv =====
// shared types and constants for the sorted tick task scheduler
// no dependencies
package stts_pkg;

    localparam int unsigned MaxTasksDef = 16;
    localparam int unsigned TickMsDef   = 10;
    localparam int unsigned MaxResults  = 16;

    typedef enum logic [1:0] {
        K_TICK   = 2'd0,
        K_ADD    = 2'd1,
        K_DELETE = 2'd2,
        K_DISP   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_NONE     = 2'd3
    } t_status;

endpackage

// ===== rtl/sorted_tick_task_scheduler.sv =====
// sorted tick task scheduler: task table, sorted due list, one shared walker
// depends on stts_pkg
//
//  channel  | direction | handshake           | payload
//  input    | in        | i_valid / o_ready   | kind, task_handle, start_delay,
//           |           |                     | repeat_period, target_id
//  result   | out       | o_valid / i_ready   | status, task_ident, run_handle,
//           |           |                     | slot, time_ms, last
//
// one word at a time; every step walks one slot or one list link per cycle,
// save that the dispatch scan waits while a result is held. add and delete
// are bounded by the slot scan and the list walk, a tick by the list walks
// that reinsert tasks, a dispatch by the slot scan and the walks that retire them.
// a held result stops the sequencer until i_ready; synchronous reset clears
// the list, the slot flags and the counters.
module sorted_tick_task_scheduler #(
    parameter int unsigned MAX_TASKS = stts_pkg::MaxTasksDef,
    parameter int unsigned TICK_MS   = stts_pkg::TickMsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_task_handle,
    input  logic [31:0] i_start_delay,
    input  logic [31:0] i_repeat_period,
    input  logic [31:0] i_target_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_task_ident,
    output logic [7:0]  o_run_handle,
    output logic [5:0]  o_slot,
    output logic [31:0] o_time_ms,
    output logic        o_last
);
    localparam int unsigned SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int unsigned LW = SW + 1;            // link width, msb = no task
    localparam int unsigned CW = $clog2(stts_pkg::MaxResults + 1);
    localparam logic [LW-1:0] NoLink = {1'b1, {SW{1'b0}}};
    localparam logic [SW-1:0] LastSlot = SW'(MAX_TASKS - 1);
    localparam logic [CW-1:0] LastRes = CW'(stts_pkg::MaxResults - 1);
    localparam logic [31:0] TickMs = 32'(TICK_MS);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b00000001,
        S_SCAN    = 8'b00000010,
        S_POP     = 8'b00000100,
        S_INSH    = 8'b00001000,
        S_INSW    = 8'b00010000,
        S_UNLINK  = 8'b00100000,
        S_EMIT    = 8'b01000000,
        S_DISP    = 8'b10000000
    } t_state;

    t_state r_state, n_state;

    logic              r_used   [MAX_TASKS];
    logic [7:0]        r_handle [MAX_TASKS];
    logic [31:0]       r_due    [MAX_TASKS];
    logic [31:0]       r_period [MAX_TASKS];
    logic [7:0]        r_pend   [MAX_TASKS];
    logic [31:0]       r_ident  [MAX_TASKS];
    logic [LW-1:0]     r_next   [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_popped;
    logic [LW-1:0]     r_head;
    logic [31:0]       r_tick, r_idc, r_time_ms;

    // item latches and walker registers
    logic [1:0]  r_kind;
    logic [7:0]  r_ihandle;
    logic [31:0] r_idelay, r_iperiod, r_itarget;
    logic [SW-1:0] r_idx;      // scan index
    logic [SW-1:0] r_sel;      // slot being inserted / unlinked
    logic [LW-1:0] r_cur;      // list walker
    logic [CW-1:0] r_nres;     // dispatch words sent so far
    logic        r_disp_ret;   // after unlink go back to dispatch

    // result register
    logic        r_ovalid;
    logic [1:0]  r_ostatus;
    logic [31:0] r_oident;
    logic [7:0]  r_ohandle;
    logic [5:0]  r_oslot;
    logic        r_olast;

    assign o_ready      = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid      = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_task_ident = r_oident;
    assign o_run_handle = r_ohandle;
    assign o_slot       = r_oslot;
    assign o_time_ms    = r_time_ms;
    assign o_last       = r_olast;

    logic out_free;
    assign out_free = !r_ovalid || i_ready;

    logic [SW-1:0] cur_s, nxt_s;
    logic          nxt_ok;
    assign cur_s  = r_cur[SW-1:0];
    assign nxt_s  = r_next[cur_s][SW-1:0];
    assign nxt_ok = !r_next[cur_s][SW];
    logic [SW-1:0] head_s;
    assign head_s = r_head[SW-1:0];

    // another ready slot above the scan index, or the result cap, decides the last flag
    logic disp_more;
    always_comb begin
        disp_more = 1'b0;
        for (int i = 0; i < MAX_TASKS; i++)
            if (SW'(i) > r_idx && r_used[i] && r_pend[i] != '0) disp_more = 1'b1;
    end

    logic disp_hit, disp_final, emit_word;
    assign disp_hit   = r_used[r_idx] && r_pend[r_idx] != '0;
    assign disp_final = !disp_more || (r_nres == LastRes);
    assign emit_word  = out_free && ((r_state == S_EMIT) || (r_state == S_DISP && disp_hit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= NoLink;
            r_tick    <= '0;
            r_time_ms <= '0;
            r_idc     <= 32'd1;
            r_ovalid  <= 1'b0;
            r_popped  <= '0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_used[i]   <= 1'b0;
                r_due[i]    <= '0;
                r_period[i] <= '0;
                r_pend[i]   <= '0;
                r_ident[i]  <= '0;
                r_next[i]   <= NoLink;
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= emit_word || (r_ovalid && !i_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_kind    <= i_kind;
                        r_ihandle <= i_task_handle;
                        r_idelay  <= i_start_delay;
                        r_iperiod <= i_repeat_period;
                        r_itarget <= i_target_id;
                        r_idx     <= '0;
                        r_nres    <= '0;
                        r_popped  <= '0;
                        if (i_kind == stts_pkg::K_TICK) begin
                            r_tick    <= r_tick + 32'd1;
                            r_time_ms <= r_time_ms + TickMs;
                        end
                    end
                end
                S_SCAN: begin
                    // add: first free, delete: first id match
                    if (r_kind == stts_pkg::K_ADD && !r_used[r_idx]) begin
                        r_used[r_idx]   <= 1'b1;
                        r_handle[r_idx] <= r_ihandle;
                        r_due[r_idx]    <= r_tick + r_idelay;
                        r_period[r_idx] <= r_iperiod;
                        r_pend[r_idx]   <= '0;
                        r_ident[r_idx]  <= r_idc;
                        r_next[r_idx]   <= NoLink;
                        r_sel           <= r_idx;
                        r_ostatus <= stts_pkg::ST_OK;
                        r_oident  <= r_idc;
                        r_ohandle <= '0;
                        r_oslot   <= 6'(r_idx);
                        r_idc     <= r_idc + 32'd1;
                    end else if (r_kind == stts_pkg::K_DELETE && r_used[r_idx]
                                 && r_ident[r_idx] == r_itarget) begin
                        r_sel      <= r_idx;
                        r_cur      <= r_head;
                        r_disp_ret <= 1'b0;
                        r_ostatus  <= stts_pkg::ST_OK;
                        r_oident   <= r_itarget;
                        r_ohandle  <= '0;
                        r_oslot    <= 6'(r_idx);
                    end else if (r_idx == LastSlot) begin
                        r_ostatus <= (r_kind == stts_pkg::K_ADD) ? stts_pkg::ST_FULL
                                                                 : stts_pkg::ST_NOTFOUND;
                        r_oident  <= '0;
                        r_ohandle <= '0;
                        r_oslot   <= '0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_POP: begin
                    if (!r_head[SW] && !r_popped[head_s] && r_tick >= r_due[head_s]) begin
                        r_popped[head_s] <= 1'b1;
                        if (r_pend[head_s] != 8'hFF) r_pend[head_s] <= r_pend[head_s] + 8'd1;
                        r_head <= r_next[head_s];
                        r_sel  <= head_s;
                        if (r_period[head_s] != '0)
                            r_due[head_s] <= r_tick + r_period[head_s];
                        else
                            r_next[head_s] <= NoLink;
                    end else begin
                        r_ostatus <= stts_pkg::ST_OK;
                        r_oident  <= '0;
                        r_ohandle <= '0;
                        r_oslot   <= '0;
                    end
                end
                S_INSH: begin
                    // insert r_sel: compare against head first
                    if (r_head[SW] || r_due[r_sel] < r_due[head_s]) begin
                        r_next[r_sel] <= r_head;
                        r_head        <= {1'b0, r_sel};
                    end else begin
                        r_cur <= r_head;
                    end
                end
                S_INSW: begin
                    if (!nxt_ok) begin
                        r_next[cur_s] <= {1'b0, r_sel};
                        r_next[r_sel] <= NoLink;
                    end else if (r_due[r_sel] < r_due[nxt_s]) begin
                        r_next[r_sel] <= {1'b0, nxt_s};
                        r_next[cur_s] <= {1'b0, r_sel};
                    end else begin
                        r_cur <= {1'b0, nxt_s};
                    end
                end
                S_UNLINK: begin
                    if (r_head == {1'b0, r_sel} || r_cur[SW]
                        || r_next[cur_s] == {1'b0, r_sel}) begin
                        if (r_head == {1'b0, r_sel})
                            r_head <= r_next[r_sel];
                        else if (!r_cur[SW])
                            r_next[cur_s] <= r_next[r_sel];
                        r_used[r_sel]   <= 1'b0;
                        r_due[r_sel]    <= '0;
                        r_period[r_sel] <= '0;
                        r_pend[r_sel]   <= '0;
                        r_ident[r_sel]  <= '0;
                        r_next[r_sel]   <= NoLink;
                    end else begin
                        r_cur <= r_next[cur_s];
                    end
                end
                S_DISP: begin
                    if (out_free) begin
                        if (disp_hit) begin
                            r_pend[r_idx] <= r_pend[r_idx] - 8'd1;
                            r_ostatus  <= stts_pkg::ST_OK;
                            r_oident   <= r_ident[r_idx];
                            r_ohandle  <= r_handle[r_idx];
                            r_oslot    <= 6'(r_idx);
                            r_olast    <= disp_final;
                            r_nres     <= r_nres + 1'b1;
                            r_sel      <= r_idx;
                            r_cur      <= r_head;
                            r_disp_ret <= 1'b1;
                            if (r_idx != LastSlot) r_idx <= r_idx + 1'b1;
                        end else if (r_idx == LastSlot) begin
                            r_ostatus <= stts_pkg::ST_NONE;
                            r_oident  <= '0;
                            r_ohandle <= '0;
                            r_oslot   <= '0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) r_olast <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid && o_ready) begin
                unique case (stts_pkg::t_kind'(i_kind))
                    stts_pkg::K_TICK: n_state = S_POP;
                    stts_pkg::K_DISP: n_state = S_DISP;
                    default:          n_state = S_SCAN;
                endcase
            end
            S_SCAN: begin
                if (r_kind == stts_pkg::K_ADD && !r_used[r_idx]) n_state = S_INSH;
                else if (r_kind == stts_pkg::K_DELETE && r_used[r_idx]
                         && r_ident[r_idx] == r_itarget) n_state = S_UNLINK;
                else if (r_idx == LastSlot) n_state = S_EMIT;
            end
            S_POP: begin
                if (!r_head[SW] && !r_popped[head_s] && r_tick >= r_due[head_s])
                    n_state = (r_period[head_s] != '0) ? S_INSH : S_POP;
                else
                    n_state = S_EMIT;
            end
            S_INSH: begin
                if (r_head[SW] || r_due[r_sel] < r_due[head_s])
                    n_state = (r_kind == stts_pkg::K_TICK) ? S_POP : S_EMIT;
                else
                    n_state = S_INSW;
            end
            S_INSW: begin
                if (!nxt_ok || r_due[r_sel] < r_due[nxt_s])
                    n_state = (r_kind == stts_pkg::K_TICK) ? S_POP : S_EMIT;
            end
            S_UNLINK: begin
                if (r_head == {1'b0, r_sel} || r_cur[SW] || r_next[cur_s] == {1'b0, r_sel})
                    n_state = !r_disp_ret ? S_EMIT : (r_olast ? S_IDLE : S_DISP);
            end
            S_DISP: begin
                if (out_free) begin
                    if (disp_hit) begin
                        if (r_period[r_idx] == '0) n_state = S_UNLINK;
                        else if (disp_final) n_state = S_IDLE;
                    end else if (r_idx == LastSlot) n_state = S_EMIT;
                end
            end
            S_EMIT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    property p_ready_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_ready |-> r_state == S_IDLE;
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("ready outside idle");

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("accepted twice");

endmodule

// ===== tb/sorted_tick_task_scheduler_tb.sv =====
// self-checking testbench for the sorted tick task scheduler
// depends on stts_pkg and rtl/sorted_tick_task_scheduler.sv
`timescale 1ns / 100ps

module sorted_tick_task_scheduler_tb;

    localparam int NSLOT = int'(stts_pkg::MaxTasksDef);
    localparam int NOLINK = 255;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  handle;
        logic [31:0] delay;
        logic [31:0] period;
        logic [31:0] target;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] ident;
        logic [7:0]  handle;
        logic [5:0]  slot;
        logic [31:0] time_ms;
        logic        last;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind = '0;
    logic [7:0]  i_task_handle = '0;
    logic [31:0] i_start_delay = '0;
    logic [31:0] i_repeat_period = '0;
    logic [31:0] i_target_id = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_task_ident;
    logic [7:0]  o_run_handle;
    logic [5:0]  o_slot;
    logic [31:0] o_time_ms;
    logic        o_last;

    sorted_tick_task_scheduler i_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    bit          used_q [NSLOT];
    logic [7:0]  hdl_q [NSLOT];
    logic [31:0] due_q [NSLOT];
    logic [31:0] per_q [NSLOT];
    logic [7:0]  runs_q [NSLOT];
    logic [31:0] id_q [NSLOT];
    int          nxt_q [NSLOT];
    int          head_q;
    logic [31:0] now_q;
    logic [31:0] next_id;

    t_cmd        pending_cmds [$];
    t_res        expected_words [$];
    int          errors = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;
    bit          hold_send = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;

    function automatic void insert_by_due(int s);
        int cur;
        if (head_q == NOLINK || due_q[s] < due_q[head_q]) begin
            nxt_q[s] = head_q;
            head_q = s;
            return;
        end
        cur = head_q;
        for (int g = 0; g < NSLOT && nxt_q[cur] != NOLINK; g++) begin
            if (due_q[s] < due_q[nxt_q[cur]]) begin
                nxt_q[s] = nxt_q[cur];
                nxt_q[cur] = s;
                return;
            end
            cur = nxt_q[cur];
        end
        nxt_q[cur] = s;
        nxt_q[s] = NOLINK;
    endfunction

    function automatic void drop_slot(int s);
        int cur;
        if (head_q == s) begin
            head_q = nxt_q[s];
        end else begin
            cur = head_q;
            for (int g = 0; g < NSLOT && cur != NOLINK && nxt_q[cur] != s; g++)
                cur = nxt_q[cur];
            if (cur != NOLINK && nxt_q[cur] == s) nxt_q[cur] = nxt_q[s];
        end
        used_q[s] = 0; hdl_q[s] = 0; due_q[s] = 0; per_q[s] = 0;
        runs_q[s] = 0; id_q[s] = 0; nxt_q[s] = NOLINK;
    endfunction

    function automatic void push_word(logic [1:0] st, logic [31:0] id, logic [7:0] h,
                                      int s);
        t_res r;
        r.status = st; r.ident = id; r.handle = h; r.slot = s[5:0];
        r.time_ms = now_q * 32'(stts_pkg::TickMsDef); r.last = 1'b0;
        expected_words.push_back(r);
    endfunction

    function automatic void predict_schedule(t_cmd c);
        bit popped [NSLOT];
        int s;
        int n;
        t_res r;
        n = 0;
        case (stts_pkg::t_kind'(c.kind))
            stts_pkg::K_TICK: begin
                foreach (popped[k]) popped[k] = 0;
                now_q++;
                while (head_q != NOLINK && !popped[head_q] && now_q >= due_q[head_q]) begin
                    s = head_q;
                    popped[s] = 1;
                    if (runs_q[s] < 8'd255) runs_q[s]++;
                    head_q = nxt_q[s];
                    if (per_q[s] > 0) begin
                        due_q[s] = now_q + per_q[s];
                        insert_by_due(s);
                    end else begin
                        nxt_q[s] = NOLINK;
                    end
                end
                push_word(stts_pkg::ST_OK, 32'd0, 8'd0, 0);
            end
            stts_pkg::K_ADD: begin
                s = 0;
                while (s < NSLOT && used_q[s]) s++;
                if (s == NSLOT) begin
                    push_word(stts_pkg::ST_FULL, 32'd0, 8'd0, 0);
                end else begin
                    used_q[s] = 1; hdl_q[s] = c.handle; due_q[s] = now_q + c.delay;
                    per_q[s] = c.period; runs_q[s] = 0; id_q[s] = next_id;
                    nxt_q[s] = NOLINK;
                    insert_by_due(s);
                    push_word(stts_pkg::ST_OK, next_id, 8'd0, s);
                    next_id++;
                end
            end
            stts_pkg::K_DELETE: begin
                s = 0;
                while (s < NSLOT && !(used_q[s] && id_q[s] == c.target)) s++;
                if (s == NSLOT) begin
                    push_word(stts_pkg::ST_NOTFOUND, 32'd0, 8'd0, 0);
                end else begin
                    drop_slot(s);
                    push_word(stts_pkg::ST_OK, c.target, 8'd0, s);
                end
            end
            default: begin
                for (int i = 0; i < NSLOT && n < int'(stts_pkg::MaxResults); i++) begin
                    if (used_q[i] && runs_q[i] > 0) begin
                        logic [31:0] id;
                        logic [7:0]  h;
                        id = id_q[i]; h = hdl_q[i];
                        runs_q[i]--;
                        if (per_q[i] == 0) drop_slot(i);
                        push_word(stts_pkg::ST_OK, id, h, i);
                        n++;
                    end
                end
                if (n == 0) push_word(stts_pkg::ST_NONE, 32'd0, 8'd0, 0);
            end
        endcase
        r = expected_words.pop_back();
        r.last = 1'b1;
        expected_words.push_back(r);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        t_cmd c;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_schedule({i_kind, i_task_handle, i_start_delay,
                                  i_repeat_period, i_target_id});
                void'(pending_cmds.pop_front());
            end
            if (!(i_valid && !o_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_cmds.size() > 0 && !hold_send) begin
                    c = pending_cmds[0];
                    i_valid <= 1'b1;
                    i_kind <= c.kind; i_task_handle <= c.handle;
                    i_start_delay <= c.delay; i_repeat_period <= c.period;
                    i_target_id <= c.target;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 18);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", o_task_ident, 32'd0);
                end else begin
                    w = expected_words.pop_front();
                    if (o_status !== w.status)
                        report_mismatch("status", 32'(o_status), 32'(w.status));
                    if (o_task_ident !== w.ident) report_mismatch("ident", o_task_ident, w.ident);
                    if (o_run_handle !== w.handle)
                        report_mismatch("handle", 32'(o_run_handle), 32'(w.handle));
                    if (o_slot !== w.slot) report_mismatch("slot", 32'(o_slot), 32'(w.slot));
                    if (o_time_ms !== w.time_ms) report_mismatch("time", o_time_ms, w.time_ms);
                    if (o_last !== w.last) report_mismatch("last", 32'(o_last), 32'(w.last));
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 18);
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(stts_pkg::t_kind k, logic [7:0] h, logic [31:0] d,
                                      logic [31:0] p, logic [31:0] t);
        t_cmd c;
        c.kind = k; c.handle = h; c.delay = d; c.period = p; c.target = t;
        return c;
    endfunction

    function automatic logic [31:0] rand_word();
        return $urandom;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || i_valid || expected_words.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int pick;
        logic [31:0] tgt;
        for (int i = 0; i < NSLOT; i++) begin
            used_q[i] = 0; hdl_q[i] = 0; due_q[i] = 0; per_q[i] = 0;
            runs_q[i] = 0; id_q[i] = 0; nxt_q[i] = NOLINK;
        end
        head_q = NOLINK; now_q = 0; next_id = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty dispatch, missing delete, extremes, full table
        pending_cmds.push_back(make_cmd(stts_pkg::K_DISP, 8'd0, 32'd0, 32'd0, 32'd0));
        pending_cmds.push_back(make_cmd(stts_pkg::K_DELETE, 8'd0, 32'd0, 32'd0,
                                        32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(stts_pkg::K_ADD, 8'hFF, 32'd0, 32'd0, 32'd0));
        pending_cmds.push_back(make_cmd(stts_pkg::K_ADD, 8'h00, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF, 32'd0));
        pending_cmds.push_back(make_cmd(stts_pkg::K_ADD, 8'hA5, 32'd1, 32'd1, 32'd0));
        pending_cmds.push_back(make_cmd(stts_pkg::K_ADD, 8'h5A, 32'd1, 32'd2, 32'd0));
        for (int i = 0; i < 13; i++)
            pending_cmds.push_back(make_cmd(stts_pkg::K_ADD, i[7:0], 32'd2, 32'd0, 32'd0));
        pending_cmds.push_back(make_cmd(stts_pkg::K_TICK, 8'd0, 32'd0, 32'd0, 32'd0));
        pending_cmds.push_back(make_cmd(stts_pkg::K_TICK, 8'd0, 32'd0, 32'd0, 32'd0));
        pending_cmds.push_back(make_cmd(stts_pkg::K_DISP, 8'd0, 32'd0, 32'd0, 32'd0));
        pending_cmds.push_back(make_cmd(stts_pkg::K_DELETE, 8'd0, 32'd0, 32'd0, 32'd2));
        pending_cmds.push_back(make_cmd(stts_pkg::K_DISP, 8'd0, 32'd0, 32'd0, 32'd0));

        // wait until all commands are sent and all words are back
        hold_send = 1'b0;
        wait_drained();

        for (int n = 0; n < 400; n++) begin
            if (n == 340) begin
                wait_drained();
                quiet = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                pending_cmds.push_back(make_cmd(stts_pkg::K_TICK, 8'($urandom), rand_word(),
                                                rand_word(), rand_word()));
            end else if (pick < 65) begin
                // mostly short delays and periods so tasks actually fire
                pending_cmds.push_back(make_cmd(stts_pkg::K_ADD, 8'($urandom),
                    ($urandom_range(0, 7) == 0) ? rand_word() : $urandom_range(0, 6),
                    ($urandom_range(0, 7) == 0) ? rand_word() : $urandom_range(0, 4),
                    rand_word()));
            end else if (pick < 80) begin
                tgt = ($urandom_range(0, 3) == 0) ? rand_word()
                                                  : next_id - $urandom_range(1, 20);
                pending_cmds.push_back(make_cmd(stts_pkg::K_DELETE, 8'($urandom), rand_word(),
                                                rand_word(), tgt));
            end else begin
                pending_cmds.push_back(make_cmd(stts_pkg::K_DISP, 8'($urandom), rand_word(),
                                                rand_word(), rand_word()));
            end
            if (pending_cmds.size() > 8) @(posedge i_clk);
            while (pending_cmds.size() > 8) @(posedge i_clk);
        end
        wait_drained();
        repeat (400) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
